FILE: rtl/priority_interrupt_dispatcher_macros.svh
// Assertion helpers used by the dispatcher datapath.
`ifndef PRIORITY_INTERRUPT_DISPATCHER_MACROS_SVH
`define PRIORITY_INTERRUPT_DISPATCHER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PID_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PID_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pid_pkg.sv
package pid_pkg;

   localparam int SLOTS = 16;
   localparam int LINES = 64;
   localparam int SLOT_W = $clog2(SLOTS);

   localparam int OP_W = 2;
   localparam int LINE_W = 6;
   localparam int HID_W = 8;
   localparam int PRIO_W = 8;
   localparam int DS_W = 4;
   localparam int PEND_W = 8;
   localparam int ST_W = 3;
   localparam int SLOT_OUT_W = 4;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   localparam logic [8:0] LINE_LIMIT = 9'(LINES);
   localparam logic [PEND_W-1:0] PEND_MAX = '1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER   = 2'd0,
      OP_UNREGISTER = 2'd1,
      OP_RAISE      = 2'd2,
      OP_DONE       = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 3'd0,
      ST_DISPATCH = 3'd1,
      ST_BAD_LINE = 3'd2,
      ST_UNREG    = 3'd3,
      ST_FULL     = 3'd4,
      ST_HALTED   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic early;
      logic last;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/pid_controller.sv
module pid_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  pid_pkg::stat_type  stat,
   output pid_pkg::cmd_type   cmd
);

   pid_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pid_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pid_pkg::CTL_IDLE: begin
            if (req_tvalid) begin
               state_in = pid_pkg::CTL_SCAN;
            end
         end
         pid_pkg::CTL_SCAN: begin
            if (stat.early || stat.last) begin
               state_in = pid_pkg::CTL_FINISH;
            end
         end
         pid_pkg::CTL_FINISH: begin
            if (stat.out_free) begin
               state_in = pid_pkg::CTL_IDLE;
            end
         end
         default: state_in = pid_pkg::CTL_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         pid_pkg::CTL_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         pid_pkg::CTL_SCAN: begin
            cmd.scan = 1'b1;
         end
         pid_pkg::CTL_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/pid_datapath.sv
`include "priority_interrupt_dispatcher_macros.svh"

module pid_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pid_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pid_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  pid_pkg::cmd_type                cmd,
   output pid_pkg::stat_type               stat
);

   localparam int SW = pid_pkg::SLOT_W;

   // latched request
   pid_pkg::op_type              op_ff;
   logic [pid_pkg::LINE_W-1:0]   line_ff;
   logic [pid_pkg::HID_W-1:0]    hid_ff;
   logic [pid_pkg::PRIO_W-1:0]   prio_ff;
   logic [pid_pkg::DS_W-1:0]     ds_ff;

   // slot table
   logic                         valid_ff [pid_pkg::SLOTS];
   logic [pid_pkg::LINE_W-1:0]   sline_ff [pid_pkg::SLOTS];
   logic [pid_pkg::PRIO_W-1:0]   sprio_ff [pid_pkg::SLOTS];
   logic [pid_pkg::HID_W-1:0]    shid_ff  [pid_pkg::SLOTS];
   logic [pid_pkg::PEND_W-1:0]   pend_ff  [pid_pkg::SLOTS];
   logic                         busy_ff  [pid_pkg::SLOTS];

   logic [SW-1:0]                idx_ff;
   logic                         halted_ff, halted_in;
   logic                         found_ff, found_in;
   logic                         any_ff, any_in;

   // running winner
   logic                         best_ok_ff, best_ok_in;
   logic [SW-1:0]                best_idx_ff;
   logic [pid_pkg::PRIO_W-1:0]   best_prio_ff;
   logic [pid_pkg::LINE_W-1:0]   best_line_ff;
   logic [pid_pkg::HID_W-1:0]    best_hid_ff;
   logic                         best_busy_ff;

   // response register
   logic                         rsp_valid_ff;
   pid_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [pid_pkg::SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [pid_pkg::HID_W-1:0]    rsp_hid_ff, rsp_hid_in;
   logic [pid_pkg::LINE_W-1:0]   rsp_line_ff, rsp_line_in;

   logic                         bad_line;
   logic                         early;
   logic                         step;
   logic                         cur_valid, cur_busy;
   logic [pid_pkg::PEND_W-1:0]   cur_pend;
   logic                         v_in, b_in;
   logic [pid_pkg::PEND_W-1:0]   p_in;
   logic                         vpb_we, fill_we;
   logic                         line_hit, cand, better;
   logic                         dispatch;

   assign bad_line = (9'(line_ff) >= pid_pkg::LINE_LIMIT);
   assign early    = halted_ff || (op_ff != pid_pkg::OP_DONE && bad_line);
   assign step     = cmd.scan && !early;

   assign stat.early    = early;
   assign stat.last     = (idx_ff == pid_pkg::LAST_SLOT);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   assign cur_valid = valid_ff[idx_ff];
   assign cur_busy  = busy_ff[idx_ff];
   assign cur_pend  = pend_ff[idx_ff];
   assign line_hit  = cur_valid && (sline_ff[idx_ff] == line_ff);

   // per-slot update for the slot under the scan index
   always_comb begin
      v_in = cur_valid;
      b_in = cur_busy;
      p_in = cur_pend;
      vpb_we = 1'b0;
      fill_we = 1'b0;
      found_in = found_ff;
      any_in = any_ff;
      unique case (op_ff)
         pid_pkg::OP_REGISTER: begin
            if (!cur_valid && !found_ff) begin
               v_in = 1'b1;
               b_in = 1'b0;
               p_in = '0;
               vpb_we = 1'b1;
               fill_we = 1'b1;
               found_in = 1'b1;
            end
         end
         pid_pkg::OP_UNREGISTER: begin
            if (line_hit && shid_ff[idx_ff] == hid_ff) begin
               v_in = 1'b0;
               b_in = 1'b0;
               p_in = '0;
               vpb_we = 1'b1;
            end
         end
         pid_pkg::OP_RAISE: begin
            if (line_hit) begin
               any_in = 1'b1;
               vpb_we = 1'b1;
               if (cur_pend != pid_pkg::PEND_MAX) begin
                  p_in = cur_pend + 1'b1;
               end
            end
         end
         pid_pkg::OP_DONE: begin
            if (8'(ds_ff) == 8'(idx_ff) && cur_valid && cur_busy) begin
               b_in = 1'b0;
               vpb_we = 1'b1;
               if (cur_pend != '0) begin
                  p_in = cur_pend - 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // selection on updated slot values
   assign cand   = v_in && (p_in != '0);
   assign better = !best_ok_ff || (sprio_ff[idx_ff] > best_prio_ff) ||
                   (sprio_ff[idx_ff] == best_prio_ff && sline_ff[idx_ff] < best_line_ff);
   assign best_ok_in = best_ok_ff || cand;

   assign dispatch = best_ok_ff && !best_busy_ff;

   always_comb begin
      rsp_status_in = pid_pkg::ST_OK;
      rsp_slot_in = '0;
      rsp_hid_in = '0;
      rsp_line_in = '0;
      halted_in = halted_ff;
      priority if (halted_ff) begin
         rsp_status_in = pid_pkg::ST_HALTED;
      end else if (op_ff != pid_pkg::OP_DONE && bad_line) begin
         rsp_status_in = pid_pkg::ST_BAD_LINE;
         halted_in = 1'b1;
      end else if (op_ff == pid_pkg::OP_REGISTER && !found_ff) begin
         rsp_status_in = pid_pkg::ST_FULL;
         halted_in = 1'b1;
      end else if (op_ff == pid_pkg::OP_RAISE && !any_ff) begin
         rsp_status_in = pid_pkg::ST_UNREG;
         halted_in = 1'b1;
      end else if ((op_ff == pid_pkg::OP_RAISE || op_ff == pid_pkg::OP_DONE) && dispatch) begin
         rsp_status_in = pid_pkg::ST_DISPATCH;
         rsp_slot_in = pid_pkg::SLOT_OUT_W'(best_idx_ff);
         rsp_hid_in = best_hid_ff;
         rsp_line_in = best_line_ff;
      end else begin
         rsp_status_in = pid_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= pid_pkg::op_type'(req_tdata[1:0]);
         line_ff <= req_tdata[7:2];
         hid_ff  <= req_tdata[15:8];
         prio_ff <= req_tdata[23:16];
         ds_ff   <= req_tdata[27:24];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         found_ff <= 1'b0;
         any_ff <= 1'b0;
         best_ok_ff <= 1'b0;
      end else if (cmd.load) begin
         idx_ff <= '0;
         found_ff <= 1'b0;
         any_ff <= 1'b0;
         best_ok_ff <= 1'b0;
      end else if (step) begin
         idx_ff <= idx_ff + 1'b1;
         found_ff <= found_in;
         any_ff <= any_in;
         best_ok_ff <= best_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && cand && better) begin
         best_idx_ff  <= idx_ff;
         best_prio_ff <= sprio_ff[idx_ff];
         best_line_ff <= sline_ff[idx_ff];
         best_hid_ff  <= shid_ff[idx_ff];
         best_busy_ff <= b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pid_pkg::SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
            pend_ff[i]  <= '0;
            busy_ff[i]  <= 1'b0;
         end
      end else if (step && vpb_we) begin
         valid_ff[idx_ff] <= v_in;
         pend_ff[idx_ff]  <= p_in;
         busy_ff[idx_ff]  <= b_in;
      end else if (cmd.finish && rsp_status_in == pid_pkg::ST_DISPATCH) begin
         busy_ff[best_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (step && fill_we) begin
         sline_ff[idx_ff] <= line_ff;
         sprio_ff[idx_ff] <= prio_ff;
         shid_ff[idx_ff]  <= hid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            halted_ff <= halted_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_hid_ff    <= rsp_hid_in;
         rsp_line_ff   <= rsp_line_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_line_ff, rsp_hid_ff, rsp_slot_ff, rsp_status_ff};

   `PID_ASSERT_NEXT(a_halt_sticks, halted_ff, halted_ff, "halted flag dropped")
   `PID_ASSERT_NEXT(a_halted_reply, cmd.finish && halted_ff, rsp_status_ff == pid_pkg::ST_HALTED, "halted block gave a non-halted reply")
   `PID_ASSERT_NOW(a_fields_zero, rsp_valid_ff && rsp_status_ff != pid_pkg::ST_DISPATCH, rsp_slot_ff == '0 && rsp_hid_ff == '0 && rsp_line_ff == '0, "non-dispatch reply carries slot data")
   `PID_ASSERT_NEXT(a_dispatch_busy, cmd.finish && rsp_status_in == pid_pkg::ST_DISPATCH, busy_ff[$past(best_idx_ff)], "dispatched slot not marked in service")

endmodule

FILE: rtl/priority_interrupt_dispatcher.sv
// Priority interrupt dispatcher with a table of pid_pkg::SLOTS handler slots.
// Each request (op: register, unregister, raise, done) is taken when the block
// is idle and answered with exactly one response. The slot table is walked one
// slot per cycle, updating that slot and folding it into the running
// highest-priority pending choice; the result is then registered into the
// response once the output register is free. A halted, or bad-line, request
// skips the walk. The response sits in an output register; a new request is
// taken while it waits. Any error halts the block until reset; while halted,
// every request answers halted.
module priority_interrupt_dispatcher (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // op[1:0], line[7:2], handler_id[15:8], prio[23:16], done_slot[27:24], zero fill
   input  logic [pid_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0], slot_out[6:3], handler_out[14:7], line_out[20:15], zero fill
   output logic [pid_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   pid_pkg::cmd_type  cmd;
   pid_pkg::stat_type stat;

   pid_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pid_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

FILE: tb/priority_interrupt_dispatcher_checker.sv
`timescale 1ns / 1ps

module priority_interrupt_dispatcher_checker
   import pid_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // op[1:0], line[7:2], handler_id[15:8], prio[23:16], done_slot[27:24], zero fill
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[2:0], slot_out[6:3], handler_out[14:7], line_out[20:15], zero fill
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   output int                     outstanding,
   output int                     mismatch_count
);

   // status sits in the low bits, as on the bus
   typedef struct packed {
      logic [LINE_W-1:0]     line;
      logic [HID_W-1:0]      handler;
      logic [SLOT_OUT_W-1:0] slot;
      status_type            status;
   } answer_t;

   logic              tbl_valid   [SLOTS];
   logic [LINE_W-1:0] tbl_line    [SLOTS];
   logic [PRIO_W-1:0] tbl_prio    [SLOTS];
   logic [HID_W-1:0]  tbl_handler [SLOTS];
   logic [PEND_W-1:0] tbl_pending [SLOTS];
   logic              tbl_busy    [SLOTS];
   logic              tbl_halted;

   answer_t expected_answers [$];

   // highest pending priority, then lower line, then lower slot
   task automatic run_selection(inout answer_t ans);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_valid[i] && tbl_pending[i] != '0) begin
            if (best < 0 || tbl_prio[i] > tbl_prio[best] ||
                (tbl_prio[i] == tbl_prio[best] && tbl_line[i] < tbl_line[best]))
               best = i;
         end
      end
      if (best >= 0 && !tbl_busy[best]) begin
         tbl_busy[best] = 1'b1;
         ans.status = ST_DISPATCH;
         ans.slot = SLOT_OUT_W'(best);
         ans.handler = tbl_handler[best];
         ans.line = tbl_line[best];
      end
   endtask

   task automatic apply_request(input logic [REQ_DATA_W-1:0] data);
      op_type            op;
      logic [LINE_W-1:0] ln;
      logic [HID_W-1:0]  hid;
      logic [PRIO_W-1:0] pr;
      logic [DS_W-1:0]   ds;
      answer_t           ans;
      int                free_idx;
      logic              hit;
      op  = op_type'(data[1:0]);
      ln  = data[7:2];
      hid = data[15:8];
      pr  = data[23:16];
      ds  = data[27:24];
      ans = '0;
      ans.status = ST_OK;
      if (tbl_halted) begin
         ans.status = ST_HALTED;
      end else if (op != OP_DONE && int'(ln) >= LINES) begin
         tbl_halted = 1'b1;
         ans.status = ST_BAD_LINE;
      end else begin
         case (op)
            OP_REGISTER: begin
               free_idx = -1;
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!tbl_valid[i]) free_idx = i;
               if (free_idx < 0) begin
                  tbl_halted = 1'b1;
                  ans.status = ST_FULL;
               end else begin
                  tbl_valid[free_idx]   = 1'b1;
                  tbl_line[free_idx]    = ln;
                  tbl_prio[free_idx]    = pr;
                  tbl_handler[free_idx] = hid;
                  tbl_pending[free_idx] = '0;
                  tbl_busy[free_idx]    = 1'b0;
               end
            end
            OP_UNREGISTER: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (tbl_valid[i] && tbl_line[i] == ln && tbl_handler[i] == hid) begin
                     tbl_valid[i]   = 1'b0;
                     tbl_pending[i] = '0;
                     tbl_busy[i]    = 1'b0;
                  end
               end
            end
            OP_RAISE: begin
               hit = 1'b0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (tbl_valid[i] && tbl_line[i] == ln) begin
                     hit = 1'b1;
                     if (tbl_pending[i] != PEND_MAX) tbl_pending[i]++;
                  end
               end
               if (!hit) begin
                  tbl_halted = 1'b1;
                  ans.status = ST_UNREG;
               end else begin
                  run_selection(ans);
               end
            end
            default: begin
               if (int'(ds) < SLOTS && tbl_valid[ds] && tbl_busy[ds]) begin
                  tbl_busy[ds] = 1'b0;
                  if (tbl_pending[ds] != '0) tbl_pending[ds]--;
               end
               run_selection(ans);
            end
         endcase
      end
      expected_answers.push_back(ans);
   endtask

   always @(posedge clock) begin
      answer_t got;
      answer_t want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i]   = 1'b0;
            tbl_pending[i] = '0;
            tbl_busy[i]    = 1'b0;
         end
         tbl_halted = 1'b0;
         expected_answers.delete();
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = answer_t'(rsp_tdata[$bits(answer_t)-1:0]);
            if (expected_answers.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with none expected: status %0d slot %0d %s",
                        $time, got.status, got.slot,
                        $sformatf("handler %0h line %0d", got.handler, got.line));
            end else begin
               want = expected_answers.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: mismatch: expected %s, got %s", $time,
                           $sformatf("status %0d slot %0d handler %0h line %0d",
                                     want.status, want.slot, want.handler, want.line),
                           $sformatf("status %0d slot %0d handler %0h line %0d",
                                     got.status, got.slot, got.handler, got.line));
               end
            end
         end
         if (req_tvalid && req_tready) apply_request(req_tdata);
         outstanding <= expected_answers.size();
      end
   end

endmodule

FILE: tb/priority_interrupt_dispatcher_test.sv
`timescale 1ns / 1ps

module priority_interrupt_dispatcher_test;
   import pid_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PER_PHASE = 36;
   localparam int SATURATE_RAISES = 260;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    outstanding;
   int                    mismatch_count;

   int send_idle_pct = 35;
   int recv_idle_pct = 82;
   int quiet_cycles = 0;

   // table occupancy as seen from the request side, used only to shape stimulus
   bit                known_valid [SLOTS];
   logic [LINE_W-1:0] known_line  [SLOTS];
   logic [HID_W-1:0]  known_hid   [SLOTS];

   priority_interrupt_dispatcher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   priority_interrupt_dispatcher_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int slots_in_use();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += known_valid[i];
      return n;
   endfunction

   function automatic bit line_in_use(input logic [LINE_W-1:0] ln);
      for (int i = 0; i < SLOTS; i++)
         if (known_valid[i] && known_line[i] == ln) return 1'b1;
      return 1'b0;
   endfunction

   function automatic int first_free_slot();
      for (int i = 0; i < SLOTS; i++)
         if (!known_valid[i]) return i;
      return -1;
   endfunction

   function automatic int pick_valid_slot();
      int n;
      int k;
      n = slots_in_use();
      if (n == 0) return -1;
      k = $urandom_range(n - 1);
      for (int i = 0; i < SLOTS; i++) begin
         if (known_valid[i]) begin
            if (k == 0) return i;
            k--;
         end
      end
      return -1;
   endfunction

   function automatic logic [LINE_W-1:0] pick_line();
      logic [LINE_W-1:0] pool [6] = '{6'd0, 6'd7, 6'd21, 6'd42, 6'd56, 6'd63};
      if ($urandom_range(3) == 0) return LINE_W'($urandom);
      return pool[$urandom_range(5)];
   endfunction

   function automatic logic [HID_W-1:0] pick_hid();
      logic [HID_W-1:0] pool [4] = '{8'h00, 8'hFF, 8'h0F, 8'hF0};
      if ($urandom_range(9) < 4) return HID_W'($urandom);
      return pool[$urandom_range(3)];
   endfunction

   function automatic logic [PRIO_W-1:0] pick_prio();
      logic [PRIO_W-1:0] pool [3] = '{8'h00, 8'hFF, 8'h80};
      if ($urandom_range(1) == 0) return PRIO_W'($urandom);
      return pool[$urandom_range(2)];
   endfunction

   task automatic send_request(input op_type op, input logic [LINE_W-1:0] ln,
                               input logic [HID_W-1:0] hid, input logic [PRIO_W-1:0] pr,
                               input logic [DS_W-1:0] ds);
      int idx;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({ds, pr, hid, ln, op});
      do @(posedge clock); while (!req_tready);
      if (op == OP_REGISTER) begin
         idx = first_free_slot();
         if (idx >= 0) begin
            known_valid[idx] = 1'b1;
            known_line[idx]  = ln;
            known_hid[idx]   = hid;
         end
      end else if (op == OP_UNREGISTER) begin
         for (int i = 0; i < SLOTS; i++)
            if (known_valid[i] && known_line[i] == ln && known_hid[i] == hid)
               known_valid[i] = 1'b0;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic random_request();
      int used;
      int roll;
      int idx;
      used = slots_in_use();
      roll = $urandom_range(99);
      idx = pick_valid_slot();
      if (used == 0 || (used < 3 && roll < 50) || (roll < 20 && used < 14)) begin
         send_request(OP_REGISTER, pick_line(), pick_hid(), pick_prio(), DS_W'($urandom));
      end else if (roll < 30) begin
         if ($urandom_range(9) < 7)
            send_request(OP_UNREGISTER, known_line[idx], known_hid[idx],
                         PRIO_W'($urandom), DS_W'($urandom));
         else
            send_request(OP_UNREGISTER, pick_line(), pick_hid(),
                         PRIO_W'($urandom), DS_W'($urandom));
      end else if (roll < 70) begin
         send_request(OP_RAISE, known_line[idx], HID_W'($urandom),
                      PRIO_W'($urandom), DS_W'($urandom));
      end else begin
         send_request(OP_DONE, LINE_W'($urandom), HID_W'($urandom), PRIO_W'($urandom),
                      ($urandom_range(4) != 0) ? DS_W'(idx) : DS_W'($urandom));
      end
   endtask

   // drive one slot's pending count into saturation and back down a little
   task automatic saturate_one_line();
      int idx;
      if (slots_in_use() == SLOTS) begin
         idx = pick_valid_slot();
         send_request(OP_UNREGISTER, known_line[idx], known_hid[idx], 8'h00, 4'h0);
      end
      idx = first_free_slot();
      send_request(OP_REGISTER, 6'd33, 8'h77, 8'hFE, 4'h0);
      for (int n = 0; n < SATURATE_RAISES; n++)
         send_request(OP_RAISE, 6'd33, HID_W'($urandom), PRIO_W'($urandom), DS_W'($urandom));
      for (int n = 0; n < 6; n++)
         send_request(OP_DONE, LINE_W'($urandom), HID_W'($urandom), PRIO_W'($urandom),
                      DS_W'(idx));
   endtask

   task automatic finish_with_halt();
      logic [LINE_W-1:0] ln;
      if ($urandom_range(1) == 0) begin
         while (slots_in_use() < SLOTS)
            send_request(OP_REGISTER, pick_line(), pick_hid(), pick_prio(), DS_W'($urandom));
         send_request(OP_REGISTER, pick_line(), pick_hid(), pick_prio(), DS_W'($urandom));
      end else begin
         ln = LINE_W'($urandom);
         while (line_in_use(ln)) ln++;
         send_request(OP_RAISE, ln, HID_W'($urandom), PRIO_W'($urandom), DS_W'($urandom));
      end
      for (int k = int'(OP_REGISTER); k <= int'(OP_DONE); k++)
         send_request(op_type'(k), LINE_W'($urandom), HID_W'($urandom),
                      PRIO_W'($urandom), DS_W'($urandom));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, ties on priority and line, busy winner, done corner cases
      send_request(OP_DONE,       6'd0,  8'h00, 8'h00, 4'd0);
      send_request(OP_UNREGISTER, 6'd63, 8'hFF, 8'hFF, 4'd15);
      send_request(OP_REGISTER,   6'd0,  8'h00, 8'h00, 4'd15);
      send_request(OP_REGISTER,   6'd63, 8'hFF, 8'hFF, 4'd0);
      send_request(OP_REGISTER,   6'd5,  8'hA5, 8'hFF, 4'd10);
      send_request(OP_REGISTER,   6'd5,  8'h5A, 8'hFF, 4'd5);
      send_request(OP_RAISE,      6'd63, 8'h00, 8'h00, 4'd15);
      send_request(OP_RAISE,      6'd5,  8'hFF, 8'hFF, 4'd0);
      send_request(OP_RAISE,      6'd0,  8'hFF, 8'hFF, 4'd15);
      send_request(OP_DONE,       6'd63, 8'hFF, 8'hFF, 4'd2);
      send_request(OP_DONE,       6'd0,  8'h00, 8'h00, 4'd5);
      send_request(OP_DONE,       6'd63, 8'hFF, 8'hFF, 4'd0);
      send_request(OP_UNREGISTER, 6'd5,  8'h5A, 8'h00, 4'd0);
      send_request(OP_DONE,       6'd0,  8'h00, 8'h00, 4'd3);
      send_request(OP_DONE,       6'd0,  8'h00, 8'h00, 4'd1);
      send_request(OP_REGISTER,   6'd42, 8'h3C, 8'h80, 4'd0);
      send_request(OP_RAISE,      6'd42, 8'h00, 8'h00, 4'd15);
      send_request(OP_DONE,       6'd21, 8'hFF, 8'h00, 4'd0);
      send_request(OP_DONE,       6'd0,  8'h00, 8'hFF, 4'd15);
      drain();

      for (int n = 0; n < RANDOM_PER_PHASE; n++) random_request();
      drain();

      send_idle_pct = 82;
      recv_idle_pct = 35;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) random_request();
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int n = 0; n < RANDOM_PER_PHASE / 2; n++) random_request();
      saturate_one_line();
      for (int n = 0; n < RANDOM_PER_PHASE / 2; n++) random_request();
      finish_with_halt();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
